// ----- sv/ntbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ntbs_pkg
// Shared constants and types for the nearest tile search block.
// ----------------------------------------------------------------------------
package ntbs_pkg;

  localparam int MAX_TILES_DEF = 256;
  localparam int MEAN_W = 16;
  localparam int VAR_W = 24;
  localparam int DIST_W = 51;
  localparam int MODE_W = 3;
  localparam int COUNT_W = 9;
  localparam int IDX_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int ENTRY_W = 4 * MEAN_W + 4 * VAR_W;

  localparam logic [MODE_W-1:0] MODE_MEAN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CMEAN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VAR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CVAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [VAR_W-1:0] var_blue;
    logic [VAR_W-1:0] var_green;
    logic [VAR_W-1:0] var_red;
    logic [VAR_W-1:0] var_all;
    logic [MEAN_W-1:0] mean_blue;
    logic [MEAN_W-1:0] mean_green;
    logic [MEAN_W-1:0] mean_red;
    logic [MEAN_W-1:0] mean_all;
  } stats_t;

  // distance unit -> scan control
  typedef struct packed {
    logic valid;
    logic [DIST_W-1:0] score;
  } dist_res_t;

endpackage

// ----- sv/ntbs_store.sv -----
// ----------------------------------------------------------------------------
// ntbs_store
// Tile statistics table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ntbs_store #(
  parameter int MAX_TILES = ntbs_pkg::MAX_TILES_DEF,
  parameter int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  ntbs_pkg::stats_t      wr_data,
  input  logic [AW-1:0]         rd_addr,
  output ntbs_pkg::stats_t      rd_data
);
  import ntbs_pkg::*;

  stats_t mem [MAX_TILES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/ntbs_dist.sv -----
// ----------------------------------------------------------------------------
// ntbs_dist
// Distance unit: abs diffs and squares in stage 1, sums in stage 2, then a
// bit-pair square root and divide by 3 for the mixed mode.
// ----------------------------------------------------------------------------
module ntbs_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ntbs_pkg::MODE_W-1:0]   mode,
  input  ntbs_pkg::stats_t              q,
  input  ntbs_pkg::stats_t              t,
  output ntbs_pkg::dist_res_t           res
);
  import ntbs_pkg::*;

  localparam int SQ_W = 34;
  localparam int RT_W = 17;

  logic [MEAN_W-1:0] dm_r;
  logic [VAR_W-1:0] dv_r;
  logic [2*MEAN_W-1:0] cm_sq_r [3];
  logic [2*VAR_W-1:0] cv_sq_r [3];
  logic [MODE_W-1:0] mode_r, mode2_r;
  logic s1_r, s2_r;
  logic [DIST_W-1:0] d2_r;
  logic [SQ_W-1:0] sq_r;
  logic [MEAN_W-1:0] dm2_r;

  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [RT_W-1:0] root_r, root_nxt;
  logic [4:0] it_r, it_nxt;
  logic busy_r, busy_nxt;

  logic [MEAN_W-1:0] cmd [3];
  logic [VAR_W-1:0] cvd [3];
  logic [DIST_W-1:0] sum_cm, sum_cv, d_sel;
  logic [RT_W-1:0] third;
  logic [RT_W+16:0] prod;
  logic mode_mix;

  function automatic logic [VAR_W-1:0] absd(input logic [VAR_W-1:0] a,
                                            input logic [VAR_W-1:0] b);
    absd = (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    cmd[0] = MEAN_W'(absd(VAR_W'(t.mean_red), VAR_W'(q.mean_red)));
    cmd[1] = MEAN_W'(absd(VAR_W'(t.mean_green), VAR_W'(q.mean_green)));
    cmd[2] = MEAN_W'(absd(VAR_W'(t.mean_blue), VAR_W'(q.mean_blue)));
    cvd[0] = absd(t.var_red, q.var_red);
    cvd[1] = absd(t.var_green, q.var_green);
    cvd[2] = absd(t.var_blue, q.var_blue);
  end

  always_ff @(posedge clk) begin
    dm_r <= MEAN_W'(absd(VAR_W'(t.mean_all), VAR_W'(q.mean_all)));
    dv_r <= absd(t.var_all, q.var_all);
    for (int c = 0; c < 3; c++) begin
      cm_sq_r[c] <= cmd[c] * cmd[c];
      cv_sq_r[c] <= cvd[c] * cvd[c];
    end
    mode_r <= mode;
  end

  always_comb begin
    sum_cm = DIST_W'(cm_sq_r[0]) + DIST_W'(cm_sq_r[1]) + DIST_W'(cm_sq_r[2]);
    sum_cv = DIST_W'(cv_sq_r[0]) + DIST_W'(cv_sq_r[1]) + DIST_W'(cv_sq_r[2]);
    unique case (mode_r)
      MODE_CMEAN: d_sel = sum_cm;
      MODE_VAR:   d_sel = DIST_W'(dv_r);
      MODE_CVAR:  d_sel = sum_cv;
      default:    d_sel = DIST_W'(dm_r);
    endcase
  end

  always_ff @(posedge clk) begin
    d2_r <= d_sel;
    sq_r <= SQ_W'(sum_cm);
    dm2_r <= dm_r;
    mode2_r <= mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
    end else begin
      s1_r <= start;
      s2_r <= s1_r;
    end
  end

  assign mode_mix = (mode2_r == MODE_MIX);

  // bit-pair root: one result bit per cycle
  always_comb begin
    rem_nxt = rem_r;
    root_nxt = root_r;
    it_nxt = it_r;
    busy_nxt = busy_r;
    if (s2_r && mode_mix) begin
      rem_nxt = sq_r;
      root_nxt = '0;
      it_nxt = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (SQ_W'(rem_r >> (2 * it_r)) >= SQ_W'({root_r, 2'b01})) begin
        rem_nxt = rem_r - (SQ_W'({root_r, 2'b01}) << (2 * it_r));
        root_nxt = {root_r[RT_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_r[RT_W-2:0], 1'b0};
      end
      if (it_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        it_nxt = it_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    it_r <= it_nxt;
  end

  // x/3 for x < 2^17: (x*43691) >> 17
  assign prod = root_r * 17'd43691;
  assign third = RT_W'(prod >> 17);

  logic fin_r;
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r <= busy_r && !busy_nxt;
      done_r <= fin_r;
    end
  end

  logic [DIST_W-1:0] mix_r;
  always_ff @(posedge clk) begin
    mix_r <= DIST_W'(dm2_r) + DIST_W'(third);
  end

  always_comb begin
    res.valid = (s2_r && !mode_mix) || done_r;
    res.score = done_r ? mix_r : d2_r;
  end

endmodule

// ----- sv/nearest_tile_by_statistics_top.sv -----
// ----------------------------------------------------------------------------
// nearest_tile_by_statistics_top
// Photomosaic nearest-tile search over a table of tile statistics.
// ----------------------------------------------------------------------------
// A load beat writes one table entry when its index is below MAX_TILES.
// A query beat scans entries 0..tiles_in_use-1 one at a time through the
// table's single read port and the distance unit; each entry is scored
// before the next is read, and in mode 4 the bit-serial square root sets
// the pace. One item is worked at a time.
module nearest_tile_by_statistics_top #(
  parameter int MAX_TILES = ntbs_pkg::MAX_TILES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, entry_index, mean_all, mean_red, mean_green, mean_blue,
  // var_all, var_red, var_green, var_blue, zero pad
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found, best_index, best_distance, zero pad
  output logic [63:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [ntbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntbs_pkg::*;

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_OUT = 3'd3;

  logic [MODE_W-1:0] mode_r;
  logic [COUNT_W-1:0] count_r;
  logic [2:0] st_r, st_nxt;
  stats_t q_r;
  logic [CW-1:0] cnt_r, cnt_nxt, lim_r;
  logic [CW-1:0] cur_r, cur_nxt;
  logic have_r, have_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [DIST_W-1:0] bd_r, bd_nxt;
  logic start_r;
  logic [MODE_W-1:0] eff_mode;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  stats_t in_stats, rd_data;
  dist_res_t res;
  logic in_op;
  logic [IDX_W-1:0] in_idx;
  logic [CW-1:0] lim_nxt;

  assign in_op = in_tdata[0];
  assign in_idx = in_tdata[8:1];
  assign in_stats = stats_t'(in_tdata[ENTRY_W+8:9]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MEAN;
      count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:  mode_r <= cfg_data[MODE_W-1:0];
        REG_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_mode = (mode_r > MODE_MIX) ? MODE_MEAN : mode_r;
  assign lim_nxt = (32'(count_r) > MAX_TILES) ? CW'(MAX_TILES) : CW'(count_r);

  assign in_tready = (st_r == ST_IDLE);
  assign wr_en = in_tvalid && in_tready && (in_op == OP_LOAD)
                 && (32'(in_idx) < MAX_TILES);
  assign wr_addr = AW'(in_idx);

  ntbs_store #(.MAX_TILES(MAX_TILES), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_stats),
    .rd_addr(AW'(cur_r)), .rd_data(rd_data)
  );

  ntbs_dist u_dist (
    .clk(clk), .rst_n(rst_n), .start(start_r), .mode(eff_mode),
    .q(q_r), .t(rd_data), .res(res)
  );

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    have_nxt = have_r;
    best_nxt = best_r;
    bd_nxt = bd_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid && in_op == OP_QUERY) begin
          cur_nxt = '0;
          cnt_nxt = '0;
          have_nxt = 1'b0;
          best_nxt = '0;
          bd_nxt = '0;
          st_nxt = (lim_nxt == '0) ? ST_OUT : ST_READ;
        end
      end
      ST_READ: st_nxt = ST_WAIT;
      ST_WAIT: begin
        if (res.valid) begin
          if (!have_r || res.score < bd_r) begin
            have_nxt = 1'b1;
            best_nxt = IDX_W'(cnt_r);
            bd_nxt = res.score;
          end
          cnt_nxt = cnt_r + 1'b1;
          cur_nxt = cur_r + 1'b1;
          st_nxt = (cnt_r + 1'b1 == lim_r) ? ST_OUT : ST_READ;
        end
      end
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      start_r <= (st_r == ST_READ);
    end
    cnt_r <= cnt_nxt;
    cur_r <= cur_nxt;
    have_r <= have_nxt;
    best_r <= best_nxt;
    bd_r <= bd_nxt;
    if (in_tvalid && in_tready) begin
      q_r <= in_stats;
      lim_r <= lim_nxt;
    end
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = {4'd0, bd_r, best_r, have_r};

  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_LOAD) |=> !out_tvalid)
    else $error("load produced a result");
  a_res_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (st_r == ST_WAIT))
    else $error("distance outside scan");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("ready during result");

endmodule
